// File: hw/rtl/ps2sc_pkg.sv
// Shared types, character constants and key translation tables for the scan code translator.
package ps2sc_pkg;

    localparam int ScanW   = 8;
    localparam int CharW   = 7;
    localparam int CodeW   = 7;
    localparam int IndexW  = 6;
    localparam int TableDepth = 64;

    localparam int QueueDepthDefault = 4;

    // Raw bytes with a meaning of their own.
    localparam logic [ScanW-1:0] ByteExt   = 8'hE0;
    localparam logic [ScanW-1:0] ByteBksp  = 8'h0E;
    localparam logic [ScanW-1:0] ByteTab   = 8'h0F;
    localparam logic [ScanW-1:0] ByteEnter = 8'h1C;

    // Key codes, with the release bit stripped.
    localparam logic [CodeW-1:0] CodeCaps   = 7'h3A;
    localparam logic [CodeW-1:0] CodeLshift = 7'h2A;
    localparam logic [CodeW-1:0] CodeRshift = 7'h36;
    localparam logic [CodeW-1:0] CodeCtrl   = 7'h1D;
    localparam logic [CodeW-1:0] CodeLast   = 7'h39;

    localparam logic [CharW-1:0] CharSpace     = 7'h20;
    localparam logic [CharW-1:0] CharCaret     = 7'h5E;
    localparam logic [CharW-1:0] CharBackslash = 7'h5C;

    // One key press on its way from the front end to the lookup stage.
    typedef struct packed {
        logic [CharW-1:0]  prefix;
        logic [IndexW-1:0] index;
        logic              upper;
        logic              ctrl;
    } cmd_t;

    localparam logic [CharW-1:0] PlainTable [TableDepth] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h62, 7'h74,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h6E, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [CharW-1:0] ShiftedTable [TableDepth] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

// File: hw/rtl/ps2sc_if.sv
// Valid/ready channel interfaces for scan bytes in and translated characters out.
interface ps2sc_byte_if;
    import ps2sc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ScanW-1:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2sc_char_if;
    import ps2sc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CharW-1:0] prefix_char;
    logic [CharW-1:0] key_char;
    logic             ctrl_held;

    modport source (output valid, output prefix_char, output key_char, output ctrl_held,
                    input ready);
    modport sink   (input valid, input prefix_char, input key_char, input ctrl_held,
                    output ready);
endinterface

// File: hw/rtl/ps2_scancode_to_ascii.sv
// Top level of the scan code set 1 to ASCII translator.
// Takes one raw set 1 keyboard byte per transfer and gives, for each press of an ordinary
// key, one transfer with the current prefix character (space, caret or backslash), the
// ASCII code of the key (zero where the table has none) and the state of ctrl. Modifier
// keys and releases update state but give no result; extension bytes and codes above 0x39 give none either.
// A byte can be taken every clock cycle unless the input stalls; each result passes through a
// command queue entry and then the output register. The command queue holds QueueDepth
// presses and the output register one more, so the input only stalls once the output side
// has held back QueueDepth + 1 results.
module ps2_scancode_to_ascii #(
    parameter int QueueDepth = ps2sc_pkg::QueueDepthDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    ps2sc_byte_if.sink   keys,
    ps2sc_char_if.source chars
);
    import ps2sc_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    ps2sc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .keys     (keys),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ps2sc_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ps2sc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .chars      (chars)
    );

endmodule

// File: hw/rtl/ps2sc_front.sv
// Front end: takes scan bytes, tracks modifier flags and the prefix, classifies key presses.
module ps2sc_front (
    input  logic              clk,
    input  logic              rst_n,
    ps2sc_byte_if.sink        keys,
    input  logic              full,
    output logic              push,
    output ps2sc_pkg::cmd_t   push_cmd
);
    import ps2sc_pkg::*;

    logic             caps_reg,  caps_next;
    logic             shift_reg, shift_next;
    logic             ctrl_reg,  ctrl_next;
    logic [CharW-1:0] prefix_reg, prefix_next;

    logic [ScanW-1:0] raw;
    logic [CodeW-1:0] code;
    logic             press;
    logic             take;
    logic             modifier;

    function automatic logic is_shift_only(input logic [CodeW-1:0] c);
        return (c >= 7'h02 && c <= 7'h0E) || (c >= 7'h1A && c <= 7'h1C) ||
               (c >= 7'h27 && c <= 7'h29) || c == 7'h2B ||
               (c >= 7'h33 && c <= 7'h35);
    endfunction

    function automatic logic is_letter(input logic [CodeW-1:0] c);
        return (c >= 7'h10 && c <= 7'h19) || (c >= 7'h1E && c <= 7'h26) ||
               (c >= 7'h2C && c <= 7'h32);
    endfunction

    assign keys.ready = ~full;

    assign raw   = keys.scan_byte;
    assign code  = raw[CodeW-1:0];
    assign press = ~raw[ScanW-1];
    assign take  = keys.valid && keys.ready && raw != ByteExt;
    assign modifier = code == CodeLshift || code == CodeRshift || code == CodeCtrl ||
                      code == CodeCaps;

    always_comb
    begin
        caps_next   = caps_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        prefix_next = prefix_reg;
        if (take)
        begin
            if (raw == ByteBksp || raw == ByteEnter || raw == ByteTab)
            begin
                prefix_next = CharBackslash;
            end
            if (!press)
            begin
                prefix_next = CharSpace;
            end
            if (code == CodeCaps && press)
            begin
                caps_next = ~caps_reg;
            end
            if (code == CodeLshift || code == CodeRshift)
            begin
                shift_next = press;
            end
            if (code == CodeCtrl)
            begin
                ctrl_next = press;
                if (press)
                begin
                    prefix_next = CharCaret;
                end
            end
        end
    end

    // The command carries the prefix as it stands after this byte.
    always_comb
    begin
        push            = take && press && !modifier && code <= CodeLast;
        push_cmd.prefix = prefix_next;
        push_cmd.index  = code[IndexW-1:0];
        push_cmd.ctrl   = ctrl_reg;
        if (is_shift_only(code))
        begin
            push_cmd.upper = shift_reg;
        end
        else if (is_letter(code))
        begin
            push_cmd.upper = caps_reg ^ shift_reg;
        end
        else
        begin
            push_cmd.upper = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg   <= 1'b0;
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            prefix_reg <= CharSpace;
        end
        else
        begin
            caps_reg   <= caps_next;
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// File: hw/rtl/ps2sc_queue.sv
// Small first-in first-out queue of key press commands between front end and lookup stage.
module ps2sc_queue #(
    parameter int QueueDepth = ps2sc_pkg::QueueDepthDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ps2sc_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ps2sc_pkg::cmd_t head_cmd
);
    import ps2sc_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    cmd_t            entries_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = count_reg == CntW'(QueueDepth);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/ps2sc_back.sv
// Back end: looks the key up in the character tables and holds the result for the sink.
module ps2sc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ps2sc_pkg::cmd_t head_cmd,
    output logic            pop,
    ps2sc_char_if.source    chars
);
    import ps2sc_pkg::*;

    logic             valid_reg, valid_next;
    logic [CharW-1:0] prefix_reg;
    logic [CharW-1:0] key_reg;
    logic             ctrl_reg;
    logic [CharW-1:0] key_lookup;

    // The output register takes a new command when it is empty or its transfer completes.
    assign pop        = head_valid && (!valid_reg || chars.ready);
    assign key_lookup = head_cmd.upper ? ShiftedTable[head_cmd.index]
                                       : PlainTable[head_cmd.index];

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prefix_reg <= head_cmd.prefix;
            key_reg    <= key_lookup;
            ctrl_reg   <= head_cmd.ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign chars.valid       = valid_reg;
    assign chars.prefix_char = prefix_reg;
    assign chars.key_char    = key_reg;
    assign chars.ctrl_held   = ctrl_reg;

endmodule

// File: hw/rtl/ps2sc_checker.sv
// Port-level assertions for the translator, bound to its top level.
module ps2sc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] prefix_char,
    input logic [6:0] key_char,
    input logic       ctrl_held
);
    import ps2sc_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before its transfer");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(prefix_char) && $stable(key_char) &&
                                    $stable(ctrl_held))
        else $error("stalled result changed");

    a_prefix_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (prefix_char == CharSpace || prefix_char == CharCaret ||
                       prefix_char == CharBackslash))
        else $error("prefix is not space, caret or backslash");

    // A caret prefix comes only from a ctrl press, and the ctrl release resets it to a space.
    a_caret_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prefix_char == CharCaret |-> ctrl_held)
        else $error("caret prefix without ctrl held");

endmodule

bind ps2_scancode_to_ascii ps2sc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (chars.valid),
    .out_ready   (chars.ready),
    .prefix_char (chars.prefix_char),
    .key_char    (chars.key_char),
    .ctrl_held   (chars.ctrl_held)
);
